### rtl/ltd_pkg.sv
// shared types and constants for the log entry timestamp dedup block
`default_nettype none

package ltd_pkg;

  localparam int unsigned ENTRY_ID_W = 5;
  localparam int unsigned RESET_ID_W = 3;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned TICK_W     = 32;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned NOW_W      = 63;
  localparam int unsigned STAMP_W    = 64;
  localparam int unsigned REG_W      = 32;

  // one tick is 375/256 ms
  localparam int unsigned PROD_W     = 42;
  localparam int unsigned STEP_SHIFT = 8;
  localparam int unsigned OFF_W      = PROD_W - STEP_SHIFT;
  localparam logic signed [9:0] STEP_NUM = 10'sd375;
  localparam logic signed [PROD_W-1:0] RND_BIAS = PROD_W'(255);

  localparam logic MODE_REF   = 1'b0;
  localparam logic MODE_ENTRY = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_EXEC = 5'b00010,
    ST_MUL  = 5'b00100,
    ST_RND  = 5'b01000,
    ST_EMIT = 5'b10000
  } ltd_state_e;

  typedef struct packed {
    logic capture;
    logic ref_evt;
    logic ref_fix;
    logic mul;
    logic rnd;
    logic emit;
  } ltd_cmd_t;

  typedef struct packed {
    logic mode;
    logic keep;
    logic out_busy;
  } ltd_sts_t;

endpackage

`default_nettype wire

### rtl/ltd_ctrl.sv
// sequencer for reference events and log entries
`default_nettype none

module ltd_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire ltd_pkg::ltd_sts_t sts_i,
  output ltd_pkg::ltd_cmd_t      cmd_o
);
  import ltd_pkg::*;

  ltd_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts_i.mode == MODE_REF) begin
          cmd_o.ref_evt = 1'b1;
          state_d       = ST_IDLE;
        end else begin
          cmd_o.ref_fix = 1'b1;
          state_d       = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_RND;
      end
      ST_RND: begin
        cmd_o.rnd = 1'b1;
        state_d   = sts_i.keep ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        // hold until the output register is free
        if (!sts_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

`default_nettype wire

### rtl/ltd_dp.sv
// datapath: reference table, last tick table, offset arithmetic, output register
`default_nettype none

module ltd_dp #(
  parameter int unsigned NUM_ENTRY_IDS = 32,
  parameter int unsigned NUM_RESET_IDS = 8
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire ltd_pkg::ltd_cmd_t                   cmd_i,
  output ltd_pkg::ltd_sts_t                        sts_o,
  input  wire logic                                cfg_we_i,
  input  wire logic [ltd_pkg::REG_W-1:0]           cfg_data_i,
  input  wire logic                                mode_i,
  input  wire logic [ltd_pkg::BYTE_W-1:0]          entry_byte_i,
  input  wire logic [ltd_pkg::TICK_W-1:0]          tick_i,
  input  wire logic [ltd_pkg::DATA_W-1:0]          data_i,
  input  wire logic [ltd_pkg::NOW_W-1:0]           now_ms_i,
  input  wire logic                                out_stall_i,
  output logic                                     out_valid_o,
  output logic [ltd_pkg::ENTRY_ID_W-1:0]           log_id_o,
  output logic signed [ltd_pkg::STAMP_W-1:0]       timestamp_ms_o,
  output logic [ltd_pkg::DATA_W-1:0]               payload_o,
  output logic                                     registered_o
);
  import ltd_pkg::*;

  localparam int unsigned EID_W = (NUM_ENTRY_IDS > 1) ? $clog2(NUM_ENTRY_IDS) : 1;
  localparam int unsigned RID_W = (NUM_RESET_IDS > 1) ? $clog2(NUM_RESET_IDS) : 1;
  localparam int unsigned NUM_EID_CODES = 1 << ENTRY_ID_W;
  localparam int unsigned NUM_RID_CODES = 1 << RESET_ID_W;

  // id reduction tables
  logic [EID_W-1:0] eid_lut [NUM_EID_CODES];
  logic [RID_W-1:0] rid_lut [NUM_RID_CODES];

  for (genvar gi = 0; gi < NUM_EID_CODES; gi++) begin : g_eid_lut
    assign eid_lut[gi] = EID_W'(gi % NUM_ENTRY_IDS);
  end
  for (genvar gj = 0; gj < NUM_RID_CODES; gj++) begin : g_rid_lut
    assign rid_lut[gj] = RID_W'(gj % NUM_RESET_IDS);
  end

  logic [REG_W-1:0]   reg_ids_q;
  logic               mode_q;
  logic [EID_W-1:0]   eid_q;
  logic [RID_W-1:0]   rid_q;
  logic [TICK_W-1:0]  tick_q;
  logic [DATA_W-1:0]  data_q;
  logic [NOW_W-1:0]   now_q;

  logic [STAMP_W-1:0] ref_stamp_q [NUM_RESET_IDS];
  logic [TICK_W-1:0]  ref_tick_q  [NUM_RESET_IDS];
  logic [NUM_RESET_IDS-1:0] ref_valid_q;
  logic [TICK_W-1:0]  last_tick_q [NUM_ENTRY_IDS];
  logic [NUM_ENTRY_IDS-1:0] last_valid_q;

  logic signed [PROD_W-1:0] prod_q;
  logic signed [OFF_W-1:0]  off_q;
  logic [STAMP_W-1:0]       base_q;
  logic                     keep_q;

  logic                     out_valid_q;
  logic [ENTRY_ID_W-1:0]    log_id_q;
  logic [STAMP_W-1:0]       ts_q;
  logic [DATA_W-1:0]        payload_q;
  logic                     registered_q;

  logic [RESET_ID_W-1:0]    rid_code;
  logic                     found;
  logic [RID_W-1:0]         src;
  logic [RID_W-1:0]         rd_addr;
  logic [STAMP_W-1:0]       rd_stamp;
  logic [TICK_W-1:0]        rd_tick;
  logic [TICK_W-1:0]        delta;
  logic signed [PROD_W-1:0] prod_d;
  logic signed [PROD_W-1:0] biased;
  logic                     keep_d;
  logic                     out_busy;

  assign rid_code = (mode_i == MODE_ENTRY) ? entry_byte_i[BYTE_W-1 -: RESET_ID_W]
                                           : entry_byte_i[RESET_ID_W-1:0];

  // walk back from the previous reset id to the nearest valid reference
  always_comb begin
    logic [RID_W-1:0] p;
    found = 1'b0;
    src   = rid_q;
    p     = rid_q;
    for (int k = 1; k < NUM_RESET_IDS; k++) begin
      p = (p == '0) ? RID_W'(NUM_RESET_IDS - 1) : p - 1'b1;
      if (!found && ref_valid_q[p]) begin
        found = 1'b1;
        src   = p;
      end
    end
  end

  assign rd_addr  = cmd_i.ref_fix ? src : rid_q;
  assign rd_stamp = ref_stamp_q[rd_addr];
  assign rd_tick  = ref_tick_q[rd_addr];

  assign delta  = tick_q - rd_tick;
  assign prod_d = PROD_W'($signed(delta) * STEP_NUM);
  // truncate toward zero
  assign biased = prod_q + (prod_q[PROD_W-1] ? RND_BIAS : '0);
  assign keep_d = !(last_valid_q[eid_q] && !(last_tick_q[eid_q] < tick_q));

  assign out_busy = out_valid_q && out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reg_ids_q    <= '0;
      ref_valid_q  <= '0;
      last_valid_q <= '0;
      out_valid_q  <= 1'b0;
      mode_q       <= MODE_REF;
      keep_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        reg_ids_q <= cfg_data_i;
      end
      if (cmd_i.capture) begin
        mode_q <= mode_i;
      end
      if (cmd_i.ref_evt || cmd_i.ref_fix) begin
        ref_valid_q[rid_q] <= 1'b1;
      end
      if (cmd_i.mul) begin
        keep_q <= keep_d;
      end
      if (cmd_i.emit) begin
        last_valid_q[eid_q] <= 1'b1;
      end
      out_valid_q <= cmd_i.emit || out_busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      eid_q  <= eid_lut[entry_byte_i[ENTRY_ID_W-1:0]];
      rid_q  <= rid_lut[rid_code];
      tick_q <= tick_i;
      data_q <= data_i;
      now_q  <= now_ms_i;
    end
    if (cmd_i.ref_evt) begin
      ref_stamp_q[rid_q] <= STAMP_W'(now_q);
      ref_tick_q[rid_q]  <= tick_q;
    end else if (cmd_i.ref_fix && !ref_valid_q[rid_q]) begin
      if (found) begin
        ref_stamp_q[rid_q] <= rd_stamp;
        ref_tick_q[rid_q]  <= rd_tick;
      end else begin
        ref_stamp_q[rid_q] <= STAMP_W'(now_q);
        ref_tick_q[rid_q]  <= '0;
      end
    end
    if (cmd_i.mul) begin
      prod_q <= prod_d;
      base_q <= rd_stamp;
    end
    if (cmd_i.rnd) begin
      off_q <= biased[PROD_W-1:STEP_SHIFT];
    end
    if (cmd_i.emit) begin
      last_tick_q[eid_q] <= tick_q;
      log_id_q     <= ENTRY_ID_W'(eid_q);
      ts_q         <= base_q + STAMP_W'(off_q);
      payload_q    <= data_q;
      registered_q <= reg_ids_q[ENTRY_ID_W'(eid_q)];
    end
  end

  assign sts_o.mode     = mode_q;
  assign sts_o.keep     = keep_q;
  assign sts_o.out_busy = out_busy;

  assign out_valid_o    = out_valid_q;
  assign log_id_o       = log_id_q;
  assign timestamp_ms_o = $signed(ts_q);
  assign payload_o      = payload_q;
  assign registered_o   = registered_q;

endmodule

`default_nettype wire

### rtl/log_entry_timestamp_dedup.sv
// Log entry timestamping with duplicate suppression, top level.
// A kept log entry's word reaches the output register once the controller has stepped
// it from acceptance through the table read, the 32x10 multiplier, rounding and the add;
// the emit waits while the output register is busy. The block takes one item at a time:
// a new log entry or time-reference event is accepted only when the controller is idle.
// Reset clears control, valid bits and the id register; table contents are kept.
`default_nettype none

module log_entry_timestamp_dedup #(
  parameter int unsigned NUM_ENTRY_IDS = 32,
  parameter int unsigned NUM_RESET_IDS = 8
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [ltd_pkg::REG_W-1:0]     cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          mode_i,
  input  wire logic [ltd_pkg::BYTE_W-1:0]    entry_byte_i,
  input  wire logic [ltd_pkg::TICK_W-1:0]    tick_i,
  input  wire logic [ltd_pkg::DATA_W-1:0]    data_i,
  input  wire logic [ltd_pkg::NOW_W-1:0]     now_ms_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [ltd_pkg::ENTRY_ID_W-1:0]     log_id_o,
  output logic signed [ltd_pkg::STAMP_W-1:0] timestamp_ms_o,
  output logic [ltd_pkg::DATA_W-1:0]         payload_o,
  output logic                               registered_o
);
  import ltd_pkg::*;

  ltd_cmd_t cmd;
  ltd_sts_t sts;

  assign cfg_ready_o = 1'b1;

  ltd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ltd_dp #(
    .NUM_ENTRY_IDS (NUM_ENTRY_IDS),
    .NUM_RESET_IDS (NUM_RESET_IDS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .mode_i         (mode_i),
    .entry_byte_i   (entry_byte_i),
    .tick_i         (tick_i),
    .data_i         (data_i),
    .now_ms_i       (now_ms_i),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .log_id_o       (log_id_o),
    .timestamp_ms_o (timestamp_ms_o),
    .payload_o      (payload_o),
    .registered_o   (registered_o)
  );

endmodule

`default_nettype wire

### rtl/ltd_checker.sv
// port-level checks for the log entry timestamp dedup block, with bind
`default_nettype none

module ltd_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_stall_o,
  input wire logic                          mode_i,
  input wire logic                          out_valid_o,
  input wire logic                          out_stall_i,
  input wire logic signed [ltd_pkg::STAMP_W-1:0] timestamp_ms_o,
  input wire logic [ltd_pkg::DATA_W-1:0]    payload_o
);
  import ltd_pkg::*;

  // one item in flight at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted while previous item still in work");

  // a word only appears while an item is being worked on
  a_emit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("output word without an item in work");

  // a time reference event gives no word
  a_ref_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && mode_i == MODE_REF && !out_valid_o)
      |=> !out_valid_o ##1 !out_valid_o)
    else $error("time reference event produced a word");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i)
      |=> out_valid_o && $stable(timestamp_ms_o) && $stable(payload_o))
    else $error("stalled output word changed");

endmodule

bind log_entry_timestamp_dedup ltd_checker u_ltd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .mode_i         (mode_i),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .timestamp_ms_o (timestamp_ms_o),
  .payload_o      (payload_o)
);

`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 100ps
// self-checking testbench for log_entry_timestamp_dedup with a timestamp scoreboard

localparam int unsigned N_EIDS = 32;
localparam int unsigned N_RIDS = 8;

typedef struct packed {
  logic                       mode;
  logic [ltd_pkg::BYTE_W-1:0] entry_byte;
  logic [ltd_pkg::TICK_W-1:0] tick;
  logic [ltd_pkg::DATA_W-1:0] data;
  logic [ltd_pkg::NOW_W-1:0]  now_ms;
} log_item_t;

typedef struct packed {
  logic [ltd_pkg::ENTRY_ID_W-1:0] log_id;
  logic [ltd_pkg::STAMP_W-1:0]    stamp;
  logic [ltd_pkg::DATA_W-1:0]     payload;
  logic                           registered;
} stamp_word_t;

class stamp_board;
  logic [ltd_pkg::STAMP_W-1:0] ref_stamp [N_RIDS];
  logic [ltd_pkg::TICK_W-1:0]  ref_tick [N_RIDS];
  bit                          ref_valid [N_RIDS];
  logic [ltd_pkg::TICK_W-1:0]  last_tick [N_EIDS];
  bit                          last_valid [N_EIDS];
  logic [ltd_pkg::REG_W-1:0]   owned_ids;
  stamp_word_t                 stamps_due [$];
  int unsigned                 mismatch_cnt;

  function new();
    owned_ids = '0;
    mismatch_cnt = 0;
  endfunction

  // a missing reference borrows the nearest earlier reset id, else starts at tick 0
  function void adopt_reference(int unsigned rid, logic [ltd_pkg::NOW_W-1:0] now);
    int unsigned prev;
    if (ref_valid[rid]) return;
    prev = rid;
    for (int k = 1; k < N_RIDS; k++) begin
      prev = (prev + N_RIDS - 1) % N_RIDS;
      if (ref_valid[prev]) begin
        ref_stamp[rid] = ref_stamp[prev];
        ref_tick[rid] = ref_tick[prev];
        ref_valid[rid] = 1'b1;
        return;
      end
    end
    ref_stamp[rid] = {1'b0, now};
    ref_tick[rid] = '0;
    ref_valid[rid] = 1'b1;
  endfunction

  // signed tick delta times 375/256, truncated toward zero
  function logic [ltd_pkg::STAMP_W-1:0] tick_offset(logic [ltd_pkg::TICK_W-1:0] delta);
    longint scaled;
    scaled = longint'($signed(delta)) * 375;
    return 64'(scaled / 256);
  endfunction

  function void note_item(log_item_t item);
    int unsigned eid;
    int unsigned rid;
    logic [ltd_pkg::STAMP_W-1:0] stamp;
    stamp_word_t w;
    if (item.mode == ltd_pkg::MODE_REF) begin
      rid = item.entry_byte[2:0];
      ref_stamp[rid] = {1'b0, item.now_ms};
      ref_tick[rid] = item.tick;
      ref_valid[rid] = 1'b1;
      return;
    end
    eid = item.entry_byte[4:0];
    rid = item.entry_byte[7:5];
    adopt_reference(rid, item.now_ms);
    stamp = ref_stamp[rid] + tick_offset(item.tick - ref_tick[rid]);
    // stale or repeated tick for this entry id
    if (last_valid[eid] && !(last_tick[eid] < item.tick)) return;
    last_tick[eid] = item.tick;
    last_valid[eid] = 1'b1;
    w.log_id = 5'(eid);
    w.stamp = stamp;
    w.payload = item.data;
    w.registered = owned_ids[eid];
    stamps_due = {stamps_due, w};
  endfunction

  function void check_word(stamp_word_t got);
    stamp_word_t want;
    if (stamps_due.size() == 0) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10)
        $display("unexpected word: id %0d stamp %0d payload %h reg %b",
                 got.log_id, $signed(got.stamp), got.payload, got.registered);
      return;
    end
    want = stamps_due.pop_front();
    if (got.log_id !== want.log_id || got.stamp !== want.stamp ||
        got.payload !== want.payload || got.registered !== want.registered) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10)
        $display("word mismatch: expected id %0d stamp %0d payload %h reg %b,",
                 want.log_id, $signed(want.stamp), want.payload, want.registered,
                 " got id %0d stamp %0d payload %h reg %b",
                 got.log_id, $signed(got.stamp), got.payload, got.registered);
    end
  endfunction
endclass

module testbench;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned SETTLE_CYCLES = 12;

  logic                               clk_i = 1'b0;
  logic                               rst_ni;
  logic                               cfg_valid_i;
  logic                               cfg_ready_o;
  logic [ltd_pkg::REG_W-1:0]          cfg_data_i;
  logic                               in_valid_i;
  logic                               in_stall_o;
  logic                               mode_i;
  logic [ltd_pkg::BYTE_W-1:0]         entry_byte_i;
  logic [ltd_pkg::TICK_W-1:0]         tick_i;
  logic [ltd_pkg::DATA_W-1:0]         data_i;
  logic [ltd_pkg::NOW_W-1:0]          now_ms_i;
  logic                               out_valid_o;
  logic                               out_stall_i;
  logic [ltd_pkg::ENTRY_ID_W-1:0]     log_id_o;
  logic signed [ltd_pkg::STAMP_W-1:0] timestamp_ms_o;
  logic [ltd_pkg::DATA_W-1:0]         payload_o;
  logic                               registered_o;

  stamp_board  sb = new();
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_go = 1'b0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;

  always #2 clk_i = ~clk_i;

  log_entry_timestamp_dedup u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .entry_byte_i   (entry_byte_i),
    .tick_i         (tick_i),
    .data_i         (data_i),
    .now_ms_i       (now_ms_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .log_id_o       (log_id_o),
    .timestamp_ms_o (timestamp_ms_o),
    .payload_o      (payload_o),
    .registered_o   (registered_o)
  );

  // output side: check each word, then pick the next stall
  always @(posedge clk_i) begin : rx_side
    stamp_word_t seen;
    if (out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      seen.log_id = log_id_o;
      seen.stamp = timestamp_ms_o;
      seen.payload = payload_o;
      seen.registered = registered_o;
      sb.check_word(seen);
    end
    if (hold_go) begin
      hold_left = HOLD_CYCLES;
      hold_go = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_stall_o === 1'b0) ||
        (out_valid_o === 1'b1 && !out_stall_i) || (cfg_valid_i && cfg_ready_o === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[log_entry_timestamp_dedup] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_owned_ids(logic [ltd_pkg::REG_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    sb.owned_ids = value;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_item(log_item_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= item.mode;
    entry_byte_i <= item.entry_byte;
    tick_i <= item.tick;
    data_i <= item.data;
    now_ms_i <= item.now_ms;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    sb.note_item(item);
  endtask

  // results can lag behind the last expected word, so settle before touching the register
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.stamps_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic log_item_t pack_item(logic mode, logic [7:0] eb, logic [31:0] tick,
                                          logic [31:0] data, logic [62:0] now);
    log_item_t item;
    item.mode = mode;
    item.entry_byte = eb;
    item.tick = tick;
    item.data = data;
    item.now_ms = now;
    return item;
  endfunction

  function automatic log_item_t random_item();
    log_item_t   item;
    int unsigned eid;
    int unsigned roll;
    item.entry_byte = 8'($urandom);
    item.data = $urandom;
    item.now_ms = 63'({$urandom, $urandom});
    item.tick = $urandom;
    eid = item.entry_byte[4:0];
    roll = $urandom_range(99);
    if (roll < 15) begin
      item.mode = ltd_pkg::MODE_REF;
      // keep some references close to live entry ticks so offsets stay small
      if (roll < 8 && sb.last_valid[eid])
        item.tick = sb.last_tick[eid] - $urandom_range(0, 2000);
    end else begin
      item.mode = ltd_pkg::MODE_ENTRY;
      if (sb.last_valid[eid] && roll < 75)
        item.tick = sb.last_tick[eid] + $urandom_range(1, 3000);
      else if (sb.last_valid[eid] && roll < 88)
        item.tick = sb.last_tick[eid] - $urandom_range(0, 3);
    end
    return item;
  endfunction

  initial begin : main_seq
    logic [ltd_pkg::REG_W-1:0] owned;
    rst_ni <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_data_i <= '0;
    in_valid_i <= 1'b0;
    mode_i <= ltd_pkg::MODE_REF;
    entry_byte_i <= '0;
    tick_i <= '0;
    data_i <= '0;
    now_ms_i <= '0;
    out_stall_i <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_owned_ids('1);
    send_idle_pct = 20;
    recv_stall_pct = 30;
    // no reference anywhere yet: a fresh one at tick 0
    send_item(pack_item(ltd_pkg::MODE_ENTRY, {3'd5, 5'd0}, 32'd100, 32'h0, 63'd1000));
    // missing references borrow from the nearest earlier reset id, wrapping around
    send_item(pack_item(ltd_pkg::MODE_ENTRY, {3'd2, 5'd31}, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                        63'd77));
    send_item(pack_item(ltd_pkg::MODE_ENTRY, {3'd6, 5'd1}, 32'h8000_0000, 32'h1234_5678,
                        63'd5));
    send_item(pack_item(ltd_pkg::MODE_REF, 8'hF8, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                        63'h7FFF_FFFF_FFFF_FFFF));
    send_item(pack_item(ltd_pkg::MODE_ENTRY, {3'd0, 5'd2}, 32'h0, 32'hA5A5_A5A5, 63'd0));
    // large positive offset wraps the stamp
    send_item(pack_item(ltd_pkg::MODE_ENTRY, {3'd0, 5'd3}, 32'hFFFF_FFFE, 32'h5A5A_5A5A,
                        63'd0));
    send_item(pack_item(ltd_pkg::MODE_ENTRY, {3'd1, 5'd4}, 32'h7FFF_FFFF, 32'h0, 63'd9));
    // repeated and older ticks are dropped
    send_item(pack_item(ltd_pkg::MODE_ENTRY, {3'd5, 5'd0}, 32'd100, 32'h1, 63'd1));
    send_item(pack_item(ltd_pkg::MODE_ENTRY, {3'd5, 5'd0}, 32'd50, 32'h2, 63'd1));
    send_item(pack_item(ltd_pkg::MODE_ENTRY, {3'd5, 5'd0}, 32'd101, 32'h3, 63'd1));
    send_item(pack_item(ltd_pkg::MODE_REF, 8'h07, 32'h0, 32'h0, 63'd0));
    send_item(pack_item(ltd_pkg::MODE_ENTRY, {3'd7, 5'd5}, 32'h0, 32'h0, 63'd3));
    send_item(pack_item(ltd_pkg::MODE_ENTRY, {3'd7, 5'd6}, 32'd256, 32'h6, 63'd3));
    send_item(pack_item(ltd_pkg::MODE_ENTRY, {3'd7, 5'd7}, 32'hFFFF_FF00, 32'h7, 63'd3));
    send_item(pack_item(ltd_pkg::MODE_ENTRY, {3'd7, 5'd8}, 32'hFFFF_FFFF, 32'h8, 63'd3));
    // a newer reference replaces the old one
    send_item(pack_item(ltd_pkg::MODE_REF, 8'hFD, 32'd1000, 32'hDEAD_BEEF, 63'd5000));
    send_item(pack_item(ltd_pkg::MODE_ENTRY, {3'd5, 5'd9}, 32'd999, 32'h9, 63'd0));
    // dropped entry still fills in the missing reference
    send_item(pack_item(ltd_pkg::MODE_ENTRY, {3'd3, 5'd31}, 32'hFFFF_FFFF, 32'hB, 63'd42));
    send_item(pack_item(ltd_pkg::MODE_ENTRY, {3'd3, 5'd10}, 32'd5, 32'hC, 63'd42));
    send_item(pack_item(ltd_pkg::MODE_ENTRY, {3'd4, 5'd11}, 32'h8000_0001, 32'hFFFF_FFFF,
                        63'h7FFF_FFFF_FFFF_FFFF));
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 27;
          recv_stall_pct = 55;
          owned = '0;
        end
        1: begin
          send_idle_pct = 55;
          recv_stall_pct = 27;
          owned = $urandom;
        end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
          owned = $urandom;
        end
      endcase
      write_owned_ids(owned);
      // long output hold while the sender keeps pushing, to back up the input
      if (phase == 2) hold_go = 1'b1;
      repeat (phase == 2 ? 260 : 270) send_item(random_item());
      drain();
    end

    if (sb.mismatch_cnt == 0 && sb.stamps_due.size() == 0) begin
      $display("[log_entry_timestamp_dedup] OK");
    end else begin
      $display("[log_entry_timestamp_dedup] ERROR");
    end
    $finish;
  end
endmodule
